// ===== rtl/fvws_pkg.sv =====
// Package for the five-voice wavetable sound block.
// Holds the transfer payload types, the command codes and the shared constants.
// No dependencies.
package fvws_pkg;

    // Voice and table geometry
    localparam int NUM_VOICES = 5;
    localparam int WAVE_LEN   = 32;
    localparam int VOICE_W    = 3;             // voice number width
    localparam int WIDX_W     = 5;             // wave entry index width
    localparam int WADDR_W    = 8;             // wave byte address width

    localparam logic [WADDR_W-1:0] WAVE_BYTES  = 8'd160;
    localparam logic [WADDR_W-1:0] SHARED_BASE = 8'h60;
    localparam logic [WADDR_W-1:0] SHARED_END  = 8'h80;
    localparam logic [WADDR_W-1:0] FREQ_BYTES  = 8'd10;
    localparam logic [VOICE_W-1:0] FIFTH_VOICE = 3'd4;

    // Phase, step and pitch widths
    localparam int PHASE_W   = 21;
    localparam int SCALE_W   = 24;
    localparam int FREQ_W    = 12;
    localparam int DIVISOR_W = FREQ_W + 1;
    localparam int VOL_W     = 4;
    localparam int KEY_W     = 5;
    localparam int SUM_W     = 12;             // mix sum, |sum| <= 1200

    localparam logic [FREQ_W-1:0]  FREQ_MIN    = 12'd8;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd2097152;
    localparam logic [16:0]        SAMPLE_MAX  = 17'd32767;
    localparam logic [15:0]        RECIP5      = 16'hCCCD;   // 2^18 / 5, rounded up

    // Configuration register indexes (byte address 4*i)
    localparam int            APB_AW          = 3;
    localparam logic          REG_PHASE_SCALE = 1'b0;
    localparam logic          REG_SEPARATE    = 1'b1;

    // Command codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_WAVE_WR = 3'd1;
    localparam logic [2:0] CMD_WAVE_RD = 3'd2;
    localparam logic [2:0] CMD_VOLUME  = 3'd3;
    localparam logic [2:0] CMD_FREQ    = 3'd4;
    localparam logic [2:0] CMD_KEY     = 3'd5;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] address;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic        [7:0]  read_data;
        logic signed [15:0] sample_out;
    } t_out_item;

endpackage

// ===== rtl/five_voice_wavetable_sound.sv =====
// Five-voice wavetable sound block, top level.
// Wave table and phase counters live in synchronous memories; uses fvws_pkg.
//
//  channel    direction  handshake                  payload
//  in         to block   i_in_valid / o_in_ready    t_in_item (command, address, data)
//  out        from block o_out_valid / i_out_ready  t_out_item (read_data, sample_out)
//  config     to block   APB psel/penable/pwrite    phase_scale @0x0, separate_fifth_wave @0x4
//
// After reset a clearing pass zeroes the wave memory and the phase counters;
// no input transfer is taken during it (config writes are).
// A tick visits each voice in turn; each active voice runs the shared restoring divider
// for its phase step, then updates its phase and adds its contribution to the mix.
// Wave writes mirrored to the fifth voice pass through S_WR2 for the second write.
// One result register: the next transfer is taken while a result waits.
module five_voice_wavetable_sound (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  fvws_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output fvws_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fvws_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fvws_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WR2    = 4'd2;
    localparam logic [3:0] S_RDWAIT = 4'd3;
    localparam logic [3:0] S_VSTART = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_PHASE  = 4'd6;
    localparam logic [3:0] S_MAC    = 4'd7;
    localparam logic [3:0] S_SCALE  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    localparam logic [4:0] DIV_LAST = 5'(SCALE_W - 1);

    // Control and small register state
    logic [3:0]               r_state;
    logic [WADDR_W-1:0]       r_clr_addr;
    logic [7:0]               r_data;
    logic [WIDX_W-1:0]        r_addr;
    logic                     r_rd_ok;
    logic [VOICE_W-1:0]       r_voice;
    logic [4:0]               r_cnt;
    logic [FREQ_W-1:0]        r_rem;
    logic [SCALE_W-1:0]       r_quo;
    logic [DIVISOR_W-1:0]     r_div;
    logic signed [SUM_W-1:0]  r_sum;
    logic [7:0]               r_res_rd;
    logic signed [15:0]       r_res_sample;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic [SCALE_W-1:0]       r_phase_scale;
    logic                     r_sep;
    logic [FREQ_W-1:0]        r_freq [NUM_VOICES];
    logic [VOL_W-1:0]         r_vol  [NUM_VOICES];
    logic [KEY_W-1:0]         r_key;

    // Memories
    logic [7:0]               m_wave  [WAVE_BYTES];
    logic [7:0]               r_wave_q;
    logic [PHASE_W-1:0]       m_phase [NUM_VOICES];
    logic [PHASE_W-1:0]       r_phase_q;

    logic                     wave_we, wave_re;
    logic [WADDR_W-1:0]       wave_waddr, wave_raddr;
    logic [7:0]               wave_wdata;
    logic                     phase_we, phase_re;
    logic [VOICE_W-1:0]       phase_waddr;
    logic [PHASE_W-1:0]       phase_wdata;

    logic                     in_fire;
    logic                     out_load;
    logic                     cfg_wr;
    logic                     last_voice;
    logic [FREQ_W-1:0]        cur_freq;
    logic [VOL_W-1:0]         cur_vol;
    logic                     voice_active;
    logic [DIVISOR_W-1:0]     div_shift;
    logic [DIVISOR_W-1:0]     div_diff;
    logic                     div_ge;
    logic [PHASE_W-1:0]       new_phase;
    logic signed [12:0]       prod;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     neg;
    logic [SUM_W-1:0]         mag;
    logic [13:0]              mag3;
    logic [29:0]              recip_prod;
    logic [16:0]              mag_scaled;
    logic [14:0]              sat;
    logic signed [15:0]       scaled;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid & o_in_ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel & penable & pwrite;
    assign prdata      = (paddr[2] == REG_SEPARATE) ? {31'd0, r_sep} : {8'd0, r_phase_scale};

    // Current voice controls
    assign cur_freq     = r_freq[r_voice];
    assign cur_vol      = r_vol[r_voice];
    assign voice_active = (cur_vol != '0) && (cur_freq > FREQ_MIN) && r_key[r_voice];
    assign last_voice   = (r_voice == FIFTH_VOICE);

    // One restoring division step: quotient bits shift into r_quo
    assign div_shift = {r_rem, r_quo[SCALE_W-1]};
    assign div_ge    = (div_shift >= r_div);
    assign div_diff  = div_shift - r_div;

    // Phase advance (mod 2^21) and voice contribution, floor of product / 8
    assign new_phase = r_phase_q + r_quo[PHASE_W-1:0];
    assign prod      = $signed(r_wave_q) * $signed({1'b0, cur_vol});
    assign sum_next  = r_sum + SUM_W'($signed(prod[12:3]));

    // Output scaling: floor(128m/5) = 25m + floor(3m/5)
    assign neg        = r_sum[SUM_W-1];
    assign mag        = neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign mag3       = 14'(mag) + 14'({mag, 1'b0});
    assign recip_prod = 30'(mag3) * 30'(RECIP5);
    assign mag_scaled = 17'(mag) * 17'd25 + 17'(recip_prod[29:18]);
    assign sat        = (mag_scaled > SAMPLE_MAX) ? SAMPLE_MAX[14:0] : mag_scaled[14:0];
    assign scaled     = neg ? -$signed({1'b0, sat}) : $signed({1'b0, sat});

    // Memory port control
    always_comb begin
        wave_we     = 1'b0;
        wave_waddr  = r_clr_addr;
        wave_wdata  = '0;
        wave_re     = 1'b0;
        wave_raddr  = i_in_item.address;
        phase_we    = 1'b0;
        phase_waddr = r_voice;
        phase_wdata = new_phase;
        phase_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                wave_we     = 1'b1;
                phase_we    = (r_clr_addr < WADDR_W'(NUM_VOICES));
                phase_waddr = r_clr_addr[VOICE_W-1:0];
                phase_wdata = '0;
            end
            S_IDLE: begin
                wave_we    = in_fire && (i_in_item.command == CMD_WAVE_WR)
                             && (i_in_item.address < WAVE_BYTES);
                wave_waddr = i_in_item.address;
                wave_wdata = i_in_item.data;
                wave_re    = in_fire && (i_in_item.command == CMD_WAVE_RD)
                             && (i_in_item.address < WAVE_BYTES);
            end
            S_WR2: begin
                wave_we    = 1'b1;
                wave_waddr = {FIFTH_VOICE, r_addr};
                wave_wdata = r_data;
            end
            S_VSTART: begin
                phase_re = voice_active;
            end
            S_PHASE: begin
                phase_we   = 1'b1;
                wave_re    = 1'b1;
                wave_raddr = {r_voice, new_phase[PHASE_W-1 -: WIDX_W]};
            end
            default: begin
            end
        endcase
    end

    // Wave memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wave_we) begin
            m_wave[wave_waddr] <= wave_wdata;
        end
        if (wave_re) begin
            r_wave_q <= m_wave[wave_raddr];
        end
    end

    // Phase counter memory
    always_ff @(posedge i_clk) begin
        if (phase_we) begin
            m_phase[phase_waddr] <= phase_wdata;
        end
        if (phase_re) begin
            r_phase_q <= m_phase[r_voice];
        end
    end

    // Sequencer, register file and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_phase_scale <= SCALE_RESET;
            r_sep         <= 1'b0;
            r_key         <= '0;
            for (int v = 0; v < NUM_VOICES; v++) begin
                r_freq[v] <= '0;
                r_vol[v]  <= '0;
            end
        end else begin
            // configuration writes
            if (cfg_wr) begin
                case (paddr[2])
                    REG_PHASE_SCALE: r_phase_scale <= pwdata[SCALE_W-1:0];
                    REG_SEPARATE:    r_sep         <= pwdata[0];
                    default: begin
                    end
                endcase
            end

            // result register: load a new result or hand the current one out
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == WAVE_BYTES - 8'd1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + 8'd1;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_res_rd     <= '0;
                        r_res_sample <= '0;
                        r_data       <= i_in_item.data;
                        r_addr       <= i_in_item.address[WIDX_W-1:0];
                        case (i_in_item.command)
                            CMD_TICK: begin
                                r_voice <= '0;
                                r_sum   <= '0;
                                r_state <= S_VSTART;
                            end
                            CMD_WAVE_WR: begin
                                if (!r_sep && (i_in_item.address >= SHARED_BASE)
                                        && (i_in_item.address < SHARED_END)) begin
                                    r_state <= S_WR2;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            CMD_WAVE_RD: begin
                                r_rd_ok <= (i_in_item.address < WAVE_BYTES);
                                r_state <= S_RDWAIT;
                            end
                            CMD_VOLUME: begin
                                if (i_in_item.address < WADDR_W'(NUM_VOICES)) begin
                                    r_vol[i_in_item.address[VOICE_W-1:0]] <=
                                        i_in_item.data[VOL_W-1:0];
                                end
                                r_state <= S_DONE;
                            end
                            CMD_FREQ: begin
                                if (i_in_item.address < FREQ_BYTES) begin
                                    if (i_in_item.address[0]) begin
                                        r_freq[i_in_item.address[3:1]][11:8] <=
                                            i_in_item.data[3:0];
                                    end else begin
                                        r_freq[i_in_item.address[3:1]][7:0] <=
                                            i_in_item.data;
                                    end
                                end
                                r_state <= S_DONE;
                            end
                            CMD_KEY: begin
                                r_key   <= i_in_item.data[KEY_W-1:0];
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                S_RDWAIT: begin
                    r_res_rd <= r_rd_ok ? r_wave_q : 8'd0;
                    r_state  <= S_DONE;
                end
                S_VSTART: begin
                    if (voice_active) begin
                        r_rem   <= '0;
                        r_quo   <= r_phase_scale;
                        r_div   <= DIVISOR_W'(cur_freq) + 13'd1;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (last_voice) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_voice <= r_voice + 3'd1;
                    end
                end
                S_DIV: begin
                    r_rem <= div_ge ? div_diff[FREQ_W-1:0] : div_shift[FREQ_W-1:0];
                    r_quo <= {r_quo[SCALE_W-2:0], div_ge};
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_PHASE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_PHASE: begin
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_sum <= sum_next;
                    if (last_voice) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_voice <= r_voice + 3'd1;
                        r_state <= S_VSTART;
                    end
                end
                S_SCALE: begin
                    r_res_sample <= scaled;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // hand over once the result register is free
                    if (out_load) begin
                        r_out.read_data  <= r_res_rd;
                        r_out.sample_out <= r_res_sample;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== test/tb_five_voice_wavetable_sound.sv =====
// Self-checking testbench for five_voice_wavetable_sound: a table of directed commands,
// then random command streams under several register settings and idle patterns.
// Depends on fvws_pkg and the five_voice_wavetable_sound RTL only.
module tb_five_voice_wavetable_sound;
    import fvws_pkg::*;

    localparam logic [2:0] CMD_SPARE6   = 3'd6;
    localparam logic [2:0] CMD_SPARE7   = 3'd7;
    localparam int         PHASES       = 5;
    localparam int         PHASE_ITEMS  = 150;
    localparam int         LONG_HOLD    = 400;
    localparam int         DRAIN_CYCLES = 150;
    localparam int         N_DIRECTED   = 26;

    typedef struct packed {
        t_in_item  req;
        logic      typed;     // want holds a hand-written expectation
        t_out_item want;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_item   = '0;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the device state
    logic [7:0]         wave_mem    [160];
    logic [7:0]         pitch_bytes [10];
    logic [VOL_W-1:0]   vol_q       [NUM_VOICES];
    logic [KEY_W-1:0]   keys;
    logic [PHASE_W-1:0] phase_acc   [NUM_VOICES];
    logic [SCALE_W-1:0] cfg_scale;
    logic               cfg_separate;

    t_out_item results_due[$];
    int        n_fail        = 0;
    int        snd_idle_pct  = 0;
    int        rcv_idle_pct  = 0;
    bit        hold_pending  = 1'b0;

    // Directed commands; typed rows are plain after-reset, read-back or ignored cases
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{'{CMD_WAVE_RD, 8'd0,   8'h00}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_TICK,    8'd0,   8'h00}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_RD, 8'd159, 8'h00}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_RD, 8'd255, 8'hFF}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_WR, 8'd3,   8'h80}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_WR, 8'h60,  8'h81}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_WR, 8'd159, 8'h7F}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_WR, 8'd200, 8'h55}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_WAVE_RD, 8'd3,   8'h00}, 1'b1, '{8'h80, 16'sd0}},
        '{'{CMD_WAVE_RD, 8'h80,  8'h00}, 1'b1, '{8'h81, 16'sd0}},
        '{'{CMD_WAVE_RD, 8'd159, 8'h00}, 1'b1, '{8'h7F, 16'sd0}},
        '{'{CMD_WAVE_RD, 8'd200, 8'h00}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_VOLUME,  8'd0,   8'hFF}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_VOLUME,  8'd5,   8'h0F}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_VOLUME,  8'd255, 8'h0F}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_FREQ,    8'd0,   8'h09}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_FREQ,    8'd1,   8'hF0}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_FREQ,    8'd255, 8'hFF}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_KEY,     8'd0,   8'hFF}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_TICK,    8'd0,   8'h00}, 1'b0, '0},
        '{'{CMD_TICK,    8'hFF,  8'hFF}, 1'b0, '0},
        '{'{CMD_SPARE6,  8'hFF,  8'hFF}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_SPARE7,  8'hFF,  8'hFF}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_FREQ,    8'd0,   8'h08}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_TICK,    8'd0,   8'h00}, 1'b1, '{8'h00, 16'sd0}},
        '{'{CMD_FREQ,    8'd9,   8'hFF}, 1'b0, '0}
    };

    five_voice_wavetable_sound dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mix the active voices into one scaled sample, advancing their phases
    function automatic logic signed [15:0] mix_voices();
        int          mix;
        int          mag;
        int          scaled;
        int          contrib;
        int unsigned step;
        logic [11:0] pitch;
        logic [4:0]  idx;
        mix = 0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            pitch = 12'({pitch_bytes[2*v+1], pitch_bytes[2*v]});
            if (vol_q[v] != 0 && pitch > FREQ_MIN && keys[v]) begin
                step         = int'(cfg_scale) / (int'(pitch) + 1);
                phase_acc[v] = phase_acc[v] + PHASE_W'(step);
                idx          = phase_acc[v][20:16];
                contrib      = int'($signed(wave_mem[v*WAVE_LEN + idx])) * int'(vol_q[v]);
                mix         += contrib >>> 3;   // floor division by 8
            end
        end
        mag    = (mix < 0) ? -mix : mix;
        scaled = mag * 128 / 5;
        if (scaled > 32767) scaled = 32767;
        return 16'((mix < 0) ? -scaled : scaled);
    endfunction

    // Apply one command to the shadow state and return the result it yields
    function automatic t_out_item apply_command(input t_in_item it);
        t_out_item res;
        res = '0;
        case (it.command)
            CMD_TICK: begin
                res.sample_out = mix_voices();
            end
            CMD_WAVE_WR: begin
                if (it.address < WAVE_BYTES) begin
                    wave_mem[it.address] = it.data;
                    if (!cfg_separate && it.address >= SHARED_BASE)
                        wave_mem[int'(FIFTH_VOICE) * WAVE_LEN + it.address[4:0]] = it.data;
                end
            end
            CMD_WAVE_RD: begin
                if (it.address < WAVE_BYTES) res.read_data = wave_mem[it.address];
            end
            CMD_VOLUME: begin
                if (it.address < NUM_VOICES) vol_q[it.address] = it.data[3:0];
            end
            CMD_FREQ: begin
                if (it.address < FREQ_BYTES) pitch_bytes[it.address] = it.data;
            end
            CMD_KEY: begin
                keys = it.data[4:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Mostly in-range register traffic and ticks, with some noise
    function automatic t_in_item random_command();
        t_in_item it;
        int       pick;
        pick       = $urandom_range(0, 99);
        it.data    = 8'($urandom_range(0, 255));
        it.address = 8'($urandom_range(0, 255));
        if (pick < 35) begin
            it.command = CMD_TICK;
        end else if (pick < 55) begin
            it.command = CMD_WAVE_WR;
            if ($urandom_range(0, 9) != 0)
                it.address = 8'($urandom_range(0, int'(WAVE_BYTES) - 1));
        end else if (pick < 68) begin
            it.command = CMD_WAVE_RD;
            if ($urandom_range(0, 9) != 0)
                it.address = 8'($urandom_range(0, int'(WAVE_BYTES) - 1));
        end else if (pick < 76) begin
            it.command = CMD_VOLUME;
            if ($urandom_range(0, 6) != 0) it.address = 8'($urandom_range(0, NUM_VOICES - 1));
        end else if (pick < 88) begin
            it.command = CMD_FREQ;
            if ($urandom_range(0, 6) != 0)
                it.address = 8'($urandom_range(0, int'(FREQ_BYTES) - 1));
        end else if (pick < 95) begin
            it.command = CMD_KEY;
        end else begin
            it.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
        end
        return it;
    endfunction

    // One input transfer; the expectation is queued when the block takes it
    task automatic send_command(input t_in_item it, input logic typed, input t_out_item want);
        t_out_item pred;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pred = apply_command(it);
        results_due.push_back(typed ? want : pred);
    endtask

    // APB transfer; leaves psel high so transfers can run back to back
    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    // Write both registers, read them back, then update the shadow copy
    task automatic set_registers(input logic [SCALE_W-1:0] scale, input logic sep);
        logic [31:0] rb;
        apb_xfer(1'b1, {REG_PHASE_SCALE, 2'b00}, 32'(scale), rb);
        apb_xfer(1'b1, {REG_SEPARATE, 2'b00}, 32'(sep), rb);
        apb_xfer(1'b0, {REG_PHASE_SCALE, 2'b00}, '0, rb);
        if (rb[SCALE_W-1:0] !== scale) begin
            $display("%0t phase_scale readback: expected %h actual %h", $time, scale,
                     rb[SCALE_W-1:0]);
            n_fail++;
        end
        apb_xfer(1'b0, {REG_SEPARATE, 2'b00}, '0, rb);
        if (rb[0] !== sep) begin
            $display("%0t separate_fifth_wave readback: expected %b actual %b", $time, sep,
                     rb[0]);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_scale    = scale;
        cfg_separate = sep;
    endtask

    task automatic wait_all_results();
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_drain
        int hold_cnt;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h/%h", $time,
                         o_out_item.read_data, o_out_item.sample_out);
                n_fail++;
            end else begin
                want = results_due.pop_front();
                if (o_out_item.read_data !== want.read_data) begin
                    $display("%0t read_data: expected %h actual %h", $time,
                             want.read_data, o_out_item.read_data);
                    n_fail++;
                end
                if (o_out_item.sample_out !== want.sample_out) begin
                    $display("%0t sample_out: expected %0d actual %0d", $time,
                             want.sample_out, o_out_item.sample_out);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("FAIL five_voice_wavetable_sound");
        $finish;
    end

    initial begin
        logic [SCALE_W-1:0] scale;
        logic               sep;
        foreach (wave_mem[i]) wave_mem[i] = '0;
        foreach (pitch_bytes[i]) pitch_bytes[i] = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            vol_q[v]     = '0;
            phase_acc[v] = '0;
        end
        keys         = '0;
        cfg_scale    = SCALE_RESET;
        cfg_separate = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands at the reset settings
        snd_idle_pct = 32;
        rcv_idle_pct = 73;
        foreach (directed_rows[r])
            send_command(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                i_in_valid <= 1'b0;
                wait_all_results();
                case (ph)
                    1:       begin scale = 24'd1;        sep = 1'b1; end
                    2:       begin scale = 24'hFFFFFF;   sep = 1'b0; end
                    3:       begin scale = 24'($urandom_range(1, 24'hFFFFFF)); sep = 1'b1; end
                    default: begin
                        scale = 24'($urandom_range(4096, 65535));
                        sep   = 1'($urandom_range(0, 1));
                    end
                endcase
                set_registers(scale, sep);
            end
            // idle patterns: sender light / receiver heavy, swapped, then none
            case (ph % 3)
                0:       begin snd_idle_pct = 32; rcv_idle_pct = 73; end
                1:       begin snd_idle_pct = 73; rcv_idle_pct = 32; end
                default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
            endcase
            if (ph == 2) hold_pending = 1'b1;
            repeat (PHASE_ITEMS) send_command(random_command(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && results_due.size() == 0)
            $display("PASS five_voice_wavetable_sound");
        else
            $display("FAIL five_voice_wavetable_sound");
        $finish;
    end

endmodule
